FILE: hdl/stl_pkg.sv
// Package for the script token lexer: payload types, token kinds, lexer modes.
// No dependencies.
package stl_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 16;
  localparam int KW_CHARS        = 8;
  localparam int FIFO_DEPTH      = 8;

  localparam logic [5:0] K_LPAREN = 6'd14;
  localparam logic [5:0] K_RPAREN = 6'd15;
  localparam logic [5:0] K_LBRACK = 6'd16;
  localparam logic [5:0] K_RBRACK = 6'd17;
  localparam logic [5:0] K_COMMA  = 6'd18;
  localparam logic [5:0] K_PLUS   = 6'd19;
  localparam logic [5:0] K_MINUS  = 6'd20;
  localparam logic [5:0] K_STAR   = 6'd21;
  localparam logic [5:0] K_SLASH  = 6'd22;
  localparam logic [5:0] K_PCT    = 6'd23;
  localparam logic [5:0] K_ASSIGN = 6'd24;
  localparam logic [5:0] K_EQ     = 6'd25;
  localparam logic [5:0] K_LT     = 6'd26;
  localparam logic [5:0] K_LE     = 6'd27;
  localparam logic [5:0] K_GT     = 6'd28;
  localparam logic [5:0] K_GE     = 6'd29;
  localparam logic [5:0] K_EOL    = 6'd30;
  localparam logic [5:0] K_EOF    = 6'd31;
  localparam logic [5:0] K_IDENT  = 6'd32;
  localparam logic [5:0] K_STRING = 6'd33;
  localparam logic [5:0] K_INT    = 6'd34;
  localparam logic [5:0] K_DEC    = 6'd35;
  localparam logic [5:0] K_BAD    = 6'd36;
  localparam logic [5:0] K_UNTERM = 6'd37;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_EQ   = 2'd1;
  localparam logic [1:0] OP_LT   = 2'd2;
  localparam logic [1:0] OP_GT   = 2'd3;

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_WORD    = 6'b000010,
    M_NUMBER  = 6'b000100,
    M_STRING  = 6'b001000,
    M_COMMENT = 6'b010000,
    M_DROP    = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         token_kind;
    logic [15:0]        line_number;
    logic [15:0]        token_start;
    logic [15:0]        token_length;
    logic signed [31:0] number_mantissa;
    logic [4:0]         fraction_digits;
    logic [7:0]         offending_byte;
    logic               last_of_run;
  } out_item_t;

  // Up to three tokens produced by one byte, in order.
  typedef struct packed {
    logic [1:0]  count;
    out_item_t   tok0;
    out_item_t   tok1;
    out_item_t   tok2;
  } burst_t;

  function automatic logic [5:0] keyword_kind(input logic [8*KW_CHARS-1:0] w,
                                               input logic [15:0] len);
    logic [5:0] k;
    logic [63:0] s;
    k = K_IDENT;
    s = w[63:0];
    if (len <= 16'(KW_CHARS)) begin
      if (len == 3 && s[23:0] == {"d","n","a"}) k = 6'd0;
      if (len == 5 && s[39:0] == {"t","s","n","o","c"}) k = 6'd1;
      if (len == 3 && s[23:0] == {"d","n","e"}) k = 6'd2;
      if (len == 4 && s[31:0] == {"e","s","l","e"}) k = 6'd3;
      if (len == 3 && s[23:0] == {"r","o","f"}) k = 6'd4;
      if (len == 8 && s[63:0] == {"n","o","i","t","c","n","u","f"}) k = 6'd5;
      if (len == 2 && s[15:0] == {"f","i"}) k = 6'd6;
      if (len == 3 && s[23:0] == {"t","o","n"}) k = 6'd7;
      if (len == 4 && s[31:0] == {"e","n","o","n"}) k = 6'd8;
      if (len == 2 && s[15:0] == {"r","o"}) k = 6'd9;
      if (len == 6 && s[47:0] == {"n","r","u","t","e","r"}) k = 6'd10;
      if (len == 5 && s[39:0] == {"e","l","i","h","w"}) k = 6'd11;
      if (len == 2 && s[15:0] == {"o","t"}) k = 6'd12;
      if (len == 3 && s[23:0] == {"r","a","v"}) k = 6'd13;
    end
    return k;
  endfunction

endpackage

FILE: hdl/stl_front.sv
// Front end: accepts bytes, runs the lexer state and forms a burst of tokens.
// Depends on stl_pkg.
module stl_front #(
  parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_CHARS = stl_pkg::KW_CHARS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  stl_pkg::in_item_t item,
  output stl_pkg::burst_t  burst
);

  localparam logic [LINE_BITS-1:0]   LMAX = '1;
  localparam logic [OFFSET_BITS-1:0] PMAX = '1;

  stl_pkg::mode_t mode, mode_next;
  logic [8*KEYWORD_CHARS-1:0] prefix, prefix_next;
  logic [15:0] wlen, wlen_next;
  logic [31:0] acc, acc_next;
  logic [4:0]  frac, frac_next;
  logic        point, point_next;
  logic [1:0]  pend, pend_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] spos, spos_next;

  stl_pkg::out_item_t toks [3];
  logic [1:0] n;

  function automatic logic is_let(input logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return (l >= "a" && l <= "z") || b == "_";
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       last, handled, fatal;
    logic [7:0] lc;
    logic [LINE_BITS-1:0] lineinc;
    stl_pkg::out_item_t t;
    b = item.text_byte;
    last = item.end_of_text;
    handled = 1'b0;
    fatal = 1'b0;
    mode_next = mode; prefix_next = prefix; wlen_next = wlen; acc_next = acc;
    frac_next = frac; point_next = point; pend_next = pend; line_next = line;
    pos_next = pos; spos_next = spos;
    n = 2'd0;
    for (int i = 0; i < 3; i++) toks[i] = '0;
    t = '0;
    lineinc = (line < LMAX) ? line + 1'b1 : LMAX;
    lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;

    // One token slot is filled per emit; at most three can occur.
    if (mode == stl_pkg::M_DROP) begin
      if (last) begin
        mode_next = stl_pkg::M_IDLE; prefix_next = '0; wlen_next = '0; acc_next = '0;
        frac_next = '0; point_next = 1'b0; pend_next = '0; line_next = '0;
        pos_next = '0; spos_next = '0;
      end
    end else begin
      unique case (mode)
        stl_pkg::M_STRING: begin
          handled = 1'b1;
          if (b == "\"") begin
            t = '0; t.token_kind = stl_pkg::K_STRING;
            t.token_start = 16'(spos); t.token_length = wlen;
            toks[n] = t; n = n + 1'b1;
            mode_next = stl_pkg::M_IDLE;
          end else if (b == 8'h0a) begin
            t = '0; t.token_kind = stl_pkg::K_UNTERM;
            t.token_start = 16'(spos); t.token_length = wlen; t.offending_byte = 8'h0a;
            toks[n] = t; n = n + 1'b1;
            mode_next = stl_pkg::M_DROP; fatal = 1'b1;
          end else begin
            wlen_next = (wlen != 16'hffff) ? wlen + 1'b1 : wlen;
          end
        end
        stl_pkg::M_COMMENT: begin
          handled = 1'b1;
          if (b == 8'h0a) begin
            line_next = lineinc;
            t = '0; t.token_kind = stl_pkg::K_EOL;
            toks[n] = t; n = n + 1'b1;
            mode_next = stl_pkg::M_IDLE;
          end
        end
        stl_pkg::M_WORD: begin
          if (is_let(b) || is_dig(b)) begin
            handled = 1'b1;
            for (int i = 0; i < KEYWORD_CHARS; i++)
              if (wlen == 16'(i)) prefix_next[8*i +: 8] = lc;
            wlen_next = (wlen != 16'hffff) ? wlen + 1'b1 : wlen;
          end else begin
            t = '0; t.token_kind = stl_pkg::keyword_kind(prefix[63:0], wlen);
            t.token_start = 16'(spos); t.token_length = wlen;
            toks[n] = t; n = n + 1'b1;
            mode_next = stl_pkg::M_IDLE;
          end
        end
        stl_pkg::M_NUMBER: begin
          if (is_dig(b)) begin
            handled = 1'b1;
            acc_next = acc * 32'd10 + 32'(b - "0");
            if (point) frac_next = (frac != 5'd31) ? frac + 1'b1 : frac;
            wlen_next = (wlen != 16'hffff) ? wlen + 1'b1 : wlen;
          end else if (b == "." && !point) begin
            handled = 1'b1; point_next = 1'b1;
            wlen_next = (wlen != 16'hffff) ? wlen + 1'b1 : wlen;
          end else begin
            t = '0; t.token_kind = point ? stl_pkg::K_DEC : stl_pkg::K_INT;
            t.token_start = 16'(spos); t.token_length = wlen;
            t.number_mantissa = acc; t.fraction_digits = point ? frac : 5'd0;
            toks[n] = t; n = n + 1'b1;
            mode_next = stl_pkg::M_IDLE;
          end
        end
        default: begin
          mode_next = stl_pkg::M_IDLE;
          if (pend != stl_pkg::OP_NONE) begin
            pend_next = stl_pkg::OP_NONE;
            t = '0;
            if (b == "=") begin
              t.token_kind = 6'd23 + {3'd0, pend, 1'b0}; handled = 1'b1;
            end else t.token_kind = 6'd22 + {3'd0, pend, 1'b0};
            toks[n] = t; n = n + 1'b1;
          end
        end
      endcase

      if (!handled) begin
        t = '0;
        unique case (b)
          " ", 8'h09, 8'h0d: ;
          "\"": begin
            mode_next = stl_pkg::M_STRING;
            spos_next = (pos < PMAX) ? pos + 1'b1 : PMAX; wlen_next = '0;
          end
          "#": mode_next = stl_pkg::M_COMMENT;
          8'h0a: begin
            line_next = lineinc; t.token_kind = stl_pkg::K_EOL;
            toks[n] = t; n = n + 1'b1;
          end
          "(": begin t.token_kind = stl_pkg::K_LPAREN; toks[n] = t; n = n + 1'b1; end
          ")": begin t.token_kind = stl_pkg::K_RPAREN; toks[n] = t; n = n + 1'b1; end
          "[": begin t.token_kind = stl_pkg::K_LBRACK; toks[n] = t; n = n + 1'b1; end
          "]": begin t.token_kind = stl_pkg::K_RBRACK; toks[n] = t; n = n + 1'b1; end
          ",": begin t.token_kind = stl_pkg::K_COMMA; toks[n] = t; n = n + 1'b1; end
          "+": begin t.token_kind = stl_pkg::K_PLUS; toks[n] = t; n = n + 1'b1; end
          "-": begin t.token_kind = stl_pkg::K_MINUS; toks[n] = t; n = n + 1'b1; end
          "*": begin t.token_kind = stl_pkg::K_STAR; toks[n] = t; n = n + 1'b1; end
          "/": begin t.token_kind = stl_pkg::K_SLASH; toks[n] = t; n = n + 1'b1; end
          "%": begin t.token_kind = stl_pkg::K_PCT; toks[n] = t; n = n + 1'b1; end
          "=": pend_next = stl_pkg::OP_EQ;
          "<": pend_next = stl_pkg::OP_LT;
          ">": pend_next = stl_pkg::OP_GT;
          default: begin
            if (is_dig(b)) begin
              mode_next = stl_pkg::M_NUMBER; spos_next = pos; wlen_next = 16'd1;
              acc_next = 32'(b - "0"); point_next = 1'b0; frac_next = '0;
            end else if (is_let(b)) begin
              mode_next = stl_pkg::M_WORD; spos_next = pos; wlen_next = 16'd1;
              prefix_next = '0; prefix_next[7:0] = lc;
            end else begin
              t.token_kind = stl_pkg::K_BAD; t.token_start = 16'(pos);
              t.token_length = 16'd1; t.offending_byte = b;
              toks[n] = t; n = n + 1'b1;
            end
          end
        endcase
      end
      pos_next = (pos < PMAX) ? pos + 1'b1 : PMAX;

      if (last) begin
        if (!fatal) begin
          t = '0;
          if (pend_next != stl_pkg::OP_NONE) begin
            t.token_kind = 6'd22 + {3'd0, pend_next, 1'b0};
            toks[n] = t; n = n + 1'b1;
          end
          t = '0;
          if (mode_next == stl_pkg::M_WORD) begin
            t.token_kind = stl_pkg::keyword_kind(prefix_next[63:0], wlen_next);
            t.token_start = 16'(spos_next); t.token_length = wlen_next;
            toks[n] = t; n = n + 1'b1;
          end else if (mode_next == stl_pkg::M_NUMBER) begin
            t.token_kind = point_next ? stl_pkg::K_DEC : stl_pkg::K_INT;
            t.token_start = 16'(spos_next); t.token_length = wlen_next;
            t.number_mantissa = acc_next;
            t.fraction_digits = point_next ? frac_next : 5'd0;
            toks[n] = t; n = n + 1'b1;
          end
          t = '0;
          if (mode_next == stl_pkg::M_STRING) begin
            t.token_kind = stl_pkg::K_UNTERM; t.token_start = 16'(spos_next);
            t.token_length = wlen_next;
          end else t.token_kind = stl_pkg::K_EOF;
          if (n != 2'd3) begin toks[n] = t; n = n + 1'b1; end
        end
        mode_next = stl_pkg::M_IDLE; prefix_next = '0; wlen_next = '0; acc_next = '0;
        frac_next = '0; point_next = 1'b0; pend_next = '0; line_next = '0;
        pos_next = '0; spos_next = '0;
      end
    end
    // All tokens carry the line counter as it stands after this byte's update
    // up to the point of emission; EOL and later tokens share the new value.
    for (int i = 0; i < 3; i++) toks[i].line_number = 16'(line);
    if (b == 8'h0a && mode != stl_pkg::M_DROP && mode != stl_pkg::M_STRING) begin
      for (int i = 0; i < 3; i++)
        if (toks[i].token_kind == stl_pkg::K_EOL) begin
          toks[i].line_number = 16'(lineinc);
          if (i < 2) toks[i+1].line_number = 16'(lineinc);
        end
    end
    if (n != 2'd0) toks[n-1'b1].last_of_run = 1'b1;
    burst.count = take ? n : 2'd0;
    burst.tok0 = toks[0];
    burst.tok1 = toks[1];
    burst.tok2 = toks[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stl_pkg::M_IDLE; prefix <= '0; wlen <= '0; acc <= '0; frac <= '0;
      point <= 1'b0; pend <= '0; line <= '0; pos <= '0; spos <= '0;
    end else if (take) begin
      mode <= mode_next; prefix <= prefix_next; wlen <= wlen_next; acc <= acc_next;
      frac <= frac_next; point <= point_next; pend <= pend_next; line <= line_next;
      pos <= pos_next; spos <= spos_next;
    end
  end

endmodule

FILE: hdl/stl_back.sv
// Back end: token queue that absorbs bursts of up to three tokens per byte.
// Depends on stl_pkg.
module stl_back (
  input  logic               clk,
  input  logic               rst,
  input  stl_pkg::burst_t    burst,
  output logic               room,
  output logic               empty,
  input  logic               pop,
  output stl_pkg::out_item_t result
);

  localparam int D  = stl_pkg::FIFO_DEPTH;
  localparam int AW = $clog2(D);

  stl_pkg::out_item_t mem [D];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          deq;

  assign empty  = (cnt == '0);
  assign deq    = pop && !empty;
  assign result = mem[rp];
  // Room for a full burst of three.
  assign room   = (cnt <= (AW+1)'(D - 3));

  always_ff @(posedge clk) begin
    if (burst.count > 2'd0) mem[wp] <= burst.tok0;
    if (burst.count > 2'd1) mem[wp + AW'(1)] <= burst.tok1;
    if (burst.count > 2'd2) mem[wp + AW'(2)] <= burst.tok2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp  <= wp + AW'(burst.count);
      rp  <= rp + AW'(deq);
      cnt <= cnt + (AW+1)'(burst.count) - (AW+1)'(deq);
    end
  end

endmodule

FILE: hdl/script_token_lexer_unit.sv
// Top level of the script token lexer: front lexer plus token queue.
// Depends on stl_pkg, stl_front, stl_back.
//
//  channel | handshake   | payload
//  input   | push / full | in_item_t  (text_byte, end_of_text)
//  result  | pop / empty | out_item_t (token fields)
//
// One byte is taken per cycle while full is low; each byte yields zero to three
// tokens, which appear in the queue in the next cycle. full rises while the queue
// lacks room for three more tokens, so when pop stalls, its depth sets how many
// tokens are held before input stops. Reset clears the lexer state and empties the queue.
module script_token_lexer_unit #(
  parameter int LINE_BITS     = stl_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS   = stl_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_CHARS = stl_pkg::KW_CHARS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  stl_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output stl_pkg::out_item_t out_item
);

  stl_pkg::burst_t burst;
  logic room;

  assign full = !room;

  stl_front #(
    .LINE_BITS(LINE_BITS), .OFFSET_BITS(OFFSET_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk(clk), .rst(rst), .take(push && room), .item(in_item), .burst(burst)
  );

  stl_back u_back (
    .clk(clk), .rst(rst), .burst(burst), .room(room),
    .empty(empty), .pop(pop), .result(out_item)
  );

endmodule
